[design/fbfa_pkg.sv]
package fbfa_pkg;

  // Pool geometry.
  localparam int MAX_BLOCKS = 255;
  localparam int ADDR_W     = $clog2(MAX_BLOCKS);
  localparam int LINK_W     = 8;
  localparam int CNT_W      = 8;
  localparam int SIZE_W     = 9;
  localparam int OFF_W      = 16;
  localparam int PROD_W     = CNT_W + SIZE_W;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CNT_W-1:0]  MAX_BLOCKS_C      = CNT_W'(MAX_BLOCKS);
  localparam logic [SIZE_W-1:0] BLK_BYTES_RESET   = SIZE_W'(4);
  localparam logic [CNT_W-1:0]  BLOCK_COUNT_RESET = CNT_W'(255);

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_BLK_BYTES   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = CFG_IDX_W'(1);

  // Operation codes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_RANGE = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic {
    S_IDLE,
    S_ALLOC
  } fsm_t;

  // Access request toward the link store.
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [LINK_W-1:0] wr_data;
    logic              clear;
  } link_req_t;

  // Number of blocks that are really usable for a programmed count.
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] cnt);
    return (cnt > MAX_BLOCKS_C) ? MAX_BLOCKS_C : cnt;
  endfunction

endpackage

[design/fbfa_ram.sv]
module fbfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/fbfa_links.sv]
module fbfa_links
  import fbfa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  link_req_t         req,
  output logic [LINK_W-1:0] link
);

  logic [MAX_BLOCKS-1:0] valid_r;
  logic                  rd_valid_r;
  logic [ADDR_W-1:0]     rd_addr_r;
  logic [LINK_W-1:0]     ram_rdata;

  fbfa_ram #(
    .WIDTH (LINK_W),
    .DEPTH (MAX_BLOCKS)
  ) u_ram (
    .clk   (clk),
    .we    (req.wr_en),
    .waddr (req.wr_addr),
    .wdata (req.wr_data),
    .re    (req.rd_en),
    .raddr (req.rd_addr),
    .rdata (ram_rdata)
  );

  // One valid bit per entry; a rebuild clears them all at once.
  always_ff @(posedge clk) begin
    if (!rst_n || req.clear) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[req.wr_addr] <= 1'b1;
    end
  end

  // Remember which entry was read and whether it has been written since the rebuild.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_valid_r <= valid_r[req.rd_addr];
      rd_addr_r  <= req.rd_addr;
    end
  end

  // An entry never written holds its rebuilt link, the next index.
  assign link = rd_valid_r ? ram_rdata : (LINK_W'(rd_addr_r) + LINK_W'(1));

endmodule

[design/fixed_block_free_list_allocator.sv]
// Fixed-block free-list allocator.
// The input channel carries one request per transaction: in_tuser selects
// allocate (0) or free (1), and in_tdata carries the block index for a free.
// Every request produces exactly one result transaction on the out_ channel
// with a status, the allocated index, its byte offset and the free count.
// A free, or an allocate that finds the pool empty, has its result valid in the
// cycle after acceptance, and such requests can follow back to back.
// A successful allocate first reads the link of the head block from the link
// RAM, whose read port is registered, and then moves the head on in S_ALLOC,
// which waits for the output register; no request is taken in S_ALLOC.
// Results sit in an output register. A new request is taken only when that
// register is empty or its result leaves in the same cycle, so the block
// stops taking requests while the receiver stalls with a result pending.
// The cfg_ port writes the block size (index 0) or block_count (index 1) and
// is always ready; each such write, like reset, rebuilds the free list
// (entry i links to i + 1, head is block 0, all blocks free). Writes
// are only allowed while no request is in flight. Reset is synchronous and
// active low and restores a block size of 4 and a block count of 255.
module fixed_block_free_list_allocator
  import fbfa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Request channel.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] block_index
  input  logic [0:0]           in_tuser,   // [0] operation
  // Result channel.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [39:0]          out_tdata,  // [1:0] status, [9:2] given_index,
                                           // [25:10] byte_offset, [33:26] free_count,
                                           // [39:34] zero
  // Configuration write channel.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data
);

  fsm_t              state_r, state_nxt;
  logic [SIZE_W-1:0] bsize_r;
  logic [CNT_W-1:0]  bcount_r;
  logic [CNT_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  avail_r, avail_nxt;

  logic              out_valid_r;
  status_t           out_status_r, res_status;
  logic [CNT_W-1:0]  out_given_r, res_given;
  logic [OFF_W-1:0]  out_offset_r, res_offset;
  logic [CNT_W-1:0]  out_count_r, res_count;

  link_req_t         link_req;
  logic [LINK_W-1:0] link;

  logic              in_acc, cfg_acc, cfg_rebuild;
  logic              out_free, load_out, alloc_ok, free_ok;
  logic [CNT_W-1:0]  eff_cnt;
  logic [PROD_W-1:0] prod;

  fbfa_links u_links (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (link_req),
    .link  (link)
  );

  assign cfg_ready   = 1'b1;
  assign cfg_acc     = cfg_valid && cfg_ready;
  assign cfg_rebuild = cfg_acc &&
                       ((cfg_index == CFG_BLK_BYTES) || (cfg_index == CFG_BLOCK_COUNT));
  assign eff_cnt     = eff_count(bcount_r);
  assign out_free    = !out_valid_r || out_tready;
  assign in_acc      = in_tvalid && in_tready;
  assign alloc_ok    = (avail_r != '0) && (head_r < eff_cnt);
  assign free_ok     = in_tdata < eff_cnt;

  // Byte offset of the head block, saturated to 16 bits.
  assign prod = PROD_W'(head_r) * PROD_W'(bsize_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_tuser[0] == OP_ALLOC) && alloc_ok) begin
          state_nxt = S_ALLOC;
        end
      end
      S_ALLOC: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the controller: handshake, link access, result and list update.
  always_comb begin
    in_tready  = 1'b0;
    load_out   = 1'b0;
    link_req   = '0;
    res_status = STS_OK;
    res_given  = '0;
    res_offset = '0;
    res_count  = avail_r;
    head_nxt   = head_r;
    avail_nxt  = avail_r;
    unique case (state_r)
      S_IDLE: begin
        in_tready = out_free;
        if (in_acc) begin
          if (in_tuser[0] == OP_ALLOC) begin
            if (alloc_ok) begin
              link_req.rd_en   = 1'b1;
              link_req.rd_addr = head_r[ADDR_W-1:0];
            end else begin
              load_out   = 1'b1;
              res_status = STS_EMPTY;
            end
          end else begin
            load_out = 1'b1;
            if (free_ok) begin
              link_req.wr_en   = 1'b1;
              link_req.wr_addr = in_tdata[ADDR_W-1:0];
              link_req.wr_data = LINK_W'(head_r);
              head_nxt         = in_tdata;
              if (avail_r != '1) begin
                avail_nxt = avail_r + CNT_W'(1);
              end
              res_count = avail_nxt;
            end else begin
              res_status = STS_RANGE;
            end
          end
        end
      end
      S_ALLOC: begin
        if (out_free) begin
          load_out   = 1'b1;
          head_nxt   = CNT_W'(link);
          avail_nxt  = avail_r - CNT_W'(1);
          res_given  = head_r;
          res_offset = prod[PROD_W-1:OFF_W] != '0 ? '1 : prod[OFF_W-1:0];
          res_count  = avail_nxt;
        end
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
    link_req.clear = cfg_rebuild;
  end

  // Control and pool registers; a register write rebuilds the list.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      bsize_r  <= BLK_BYTES_RESET;
      bcount_r <= BLOCK_COUNT_RESET;
      head_r   <= '0;
      avail_r  <= eff_count(BLOCK_COUNT_RESET);
    end else if (cfg_rebuild) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      if (cfg_index == CFG_BLK_BYTES) begin
        bsize_r <= cfg_data;
        avail_r <= eff_cnt;
      end else begin
        bcount_r <= cfg_data[CNT_W-1:0];
        avail_r  <= eff_count(cfg_data[CNT_W-1:0]);
      end
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      avail_r <= avail_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= res_status;
      out_given_r  <= res_given;
      out_offset_r <= res_offset;
      out_count_r  <= res_count;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_count_r, out_offset_r, out_given_r, out_status_r};

`ifndef ASSERT_OFF
  // A successful allocate always goes on to read the head's link.
  a_alloc_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser[0] == OP_ALLOC) && alloc_ok) |=> (state_r == S_ALLOC))
    else $error("allocate did not enter the link read state");

  // A successful free makes the freed block the head.
  a_free_head: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser[0] == OP_FREE) && free_ok && !cfg_rebuild)
      |=> (head_r == $past(in_tdata)))
    else $error("freed block did not become the head");

  // A rebuild puts the head back on block zero.
  a_rebuild_head: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_rebuild |=> (head_r == '0) && (state_r == S_IDLE))
    else $error("rebuild did not reset the head");
`endif

endmodule

[verif/alloc_result_checker.sv]
`timescale 1ns / 100ps

// Watches the request, result and configuration channels of the allocator,
// keeps its own copy of the free list and compares every result transaction
// with the oldest predicted one.
module alloc_result_checker
  import fbfa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [7:0]           in_tdata,
  input  logic [0:0]           in_tuser,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [39:0]          out_tdata,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  output int                   mismatches,
  output int                   outstanding
);

  typedef struct packed {
    status_t           status;
    logic [7:0]        given;
    logic [OFF_W-1:0]  offset;
    logic [CNT_W-1:0]  free_cnt;
  } alloc_result_t;

  // Shadow copy of the pool: registers, link table, head and free count.
  logic [SIZE_W-1:0] size_reg;
  logic [CNT_W-1:0]  count_reg;
  logic [LINK_W-1:0] links [MAX_BLOCKS];
  logic [7:0]        head_q;
  logic [CNT_W-1:0]  free_q;

  alloc_result_t expected_results[$];

  function automatic logic [CNT_W-1:0] usable_blocks();
    return (count_reg > MAX_BLOCKS_C) ? MAX_BLOCKS_C : count_reg;
  endfunction

  // Every block links to the next one; the whole pool is free again.
  function automatic void rebuild_pool();
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      links[i] = LINK_W'(i + 1);
    end
    head_q = '0;
    free_q = usable_blocks();
  endfunction

  // Applies one request to the shadow pool and returns the result it gives.
  function automatic alloc_result_t serve_request(input logic op, input logic [7:0] idx);
    alloc_result_t     r;
    logic [CNT_W-1:0]  usable;
    logic [PROD_W-1:0] prod;
    r.status   = STS_OK;
    r.given    = '0;
    r.offset   = '0;
    usable     = usable_blocks();
    if (op == OP_ALLOC) begin
      // A head at or beyond the pool end means nothing can be handed out.
      if (free_q == 0 || head_q >= usable) begin
        r.status = STS_EMPTY;
      end else begin
        r.given  = head_q;
        prod     = PROD_W'(head_q) * PROD_W'(size_reg);
        r.offset = (prod > PROD_W'(16'hFFFF)) ? 16'hFFFF : prod[OFF_W-1:0];
        head_q   = links[head_q];
        free_q   = free_q - 1'b1;
      end
    end else begin
      // Double frees are not caught; the count only saturates.
      if (idx >= usable) begin
        r.status = STS_RANGE;
      end else begin
        links[idx] = head_q;
        head_q     = idx;
        if (free_q != 8'hFF) begin
          free_q = free_q + 1'b1;
        end
      end
    end
    r.free_cnt = free_q;
    return r;
  endfunction

  function automatic void check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // All three channels are sampled at the rising edge.
  always @(posedge clk) begin : watch_channels
    alloc_result_t want;
    if (!rst_n) begin
      size_reg  = BLK_BYTES_RESET;
      count_reg = BLOCK_COUNT_RESET;
      rebuild_pool();
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BLK_BYTES: begin
            size_reg = cfg_data;
            rebuild_pool();
          end
          CFG_BLOCK_COUNT: begin
            count_reg = cfg_data[CNT_W-1:0];
            rebuild_pool();
          end
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        expected_results.push_back(serve_request(in_tuser[0], in_tdata));
      end
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result transaction with nothing expected, actual %h",
                   $time, out_tdata);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", int'(want.status), int'(out_tdata[1:0]));
          check_field("given_index", int'(want.given), int'(out_tdata[9:2]));
          check_field("byte_offset", int'(want.offset), int'(out_tdata[25:10]));
          check_field("free_count", int'(want.free_cnt), int'(out_tdata[33:26]));
          check_field("padding", 0, int'(out_tdata[39:34]));
        end
      end
    end
    outstanding = expected_results.size();
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps

// Drives allocate and free requests into the allocator over a range of pool
// settings, with random idle bursts on both sides of the stream.
module testbench
  import fbfa_pkg::*;
();

  localparam int QUIET_LIMIT     = 2000;
  localparam int ITEMS_PER_PHASE = 110;
  localparam int RANDOM_PHASES   = 9;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata   = '0;
  logic [0:0]           in_tuser   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [39:0]          out_tdata;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [SIZE_W-1:0]    cfg_data   = '0;

  int   mismatches;
  int   outstanding;
  bit   idle_on = 1'b1;
  int   ready_hold = 0;
  int   quiet_cycles = 0;
  int   requests_sent = 0;
  int   settings_used = 1;
  int   handed_out = 0;
  int   empty_seen = 0;
  int   range_seen = 0;
  int   frees_ok = 0;

  logic       issued_ops[$];
  logic [7:0] held_blocks[$];

  always #5ns clk = ~clk;

  fixed_block_free_list_allocator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  alloc_result_checker u_result_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Receiver stalls come in bursts of random length.
  always @(negedge clk) begin
    if (ready_hold != 0) begin
      ready_hold--;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      ready_hold = $urandom_range(1, 14);
    end
    out_tready = (ready_hold == 0);
  end

  // Track which blocks the stimulus owns so that frees can hand them back.
  always @(posedge clk) begin : track_results
    logic op;
    if (rst_n && out_tvalid && out_tready && issued_ops.size() != 0) begin
      op = issued_ops.pop_front();
      case (status_t'(out_tdata[1:0]))
        STS_OK: begin
          if (op == OP_ALLOC) begin
            held_blocks.push_back(out_tdata[9:2]);
            handed_out++;
          end else begin
            frees_ok++;
          end
        end
        STS_EMPTY: empty_seen++;
        default:   range_seen++;
      endcase
    end
  end

  // Watchdog: too long without any transaction ends the run.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("[fixed_block_free_list_allocator] ERROR");
      $finish;
    end
  end

  // Presents one request, possibly after an idle burst; returns at a falling edge.
  task automatic send_request(input logic op, input logic [7:0] idx);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = idx;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    issued_ops.push_back(op);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic alloc_block();
    send_request(OP_ALLOC, 8'($urandom_range(0, 255)));
  endtask

  // Lets every outstanding result arrive before the block is touched again.
  task automatic drain_results();
    in_tvalid = 1'b0;
    wait (outstanding == 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Both writes rebuild the list, so nothing stays held afterwards.
  task automatic set_pool(input int size, input int count);
    drain_results();
    write_register(CFG_BLK_BYTES, SIZE_W'(size));
    write_register(CFG_BLOCK_COUNT, SIZE_W'(count));
    held_blocks.delete();
    settings_used++;
  endtask

  // Random traffic: mostly frees of owned blocks and allocations, with a
  // little noise that hits out-of-range indexes and double frees.
  task automatic run_random_phase(input int n_items);
    int fill_bias;
    int pick;
    fill_bias = 50;
    for (int i = 0; i < n_items; i++) begin
      if (i % 30 == 0) begin
        case ($urandom_range(0, 2))
          0:       fill_bias = 85;
          1:       fill_bias = 50;
          default: fill_bias = 20;
        endcase
      end
      if ($urandom_range(0, 99) < 8) begin
        send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end else if (held_blocks.size() == 0 || $urandom_range(0, 99) < fill_bias) begin
        alloc_block();
      end else begin
        pick = $urandom_range(0, held_blocks.size() - 1);
        send_request(OP_FREE, held_blocks[pick]);
        held_blocks.delete(pick);
      end
    end
  endtask

  initial begin : stimulus
    int size;
    int count;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part, starting from the reset settings.
    alloc_block();
    alloc_block();
    send_request(OP_FREE, 8'd0);
    alloc_block();
    send_request(OP_FREE, 8'hFF);
    send_request(OP_FREE, 8'd1);
    send_request(OP_ALLOC, 8'hFF);

    // Single-block pool: exhaustion, range check and a double free.
    set_pool(256, 1);
    alloc_block();
    alloc_block();
    send_request(OP_FREE, 8'd1);
    send_request(OP_FREE, 8'd0);
    send_request(OP_FREE, 8'd0);
    alloc_block();
    alloc_block();
    alloc_block();

    // Full pool: freeing the last block saturates the count and gives the top offset.
    set_pool(256, 255);
    send_request(OP_FREE, 8'd254);
    alloc_block();
    alloc_block();
    send_request(OP_FREE, 8'd0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin size = 1;   count = 1;   end
        1: begin size = 256; count = 255; end
        2: begin size = 3;   count = 2;   end
        3: begin size = 256; count = 8;   end
        4: begin size = 1;   count = 255; end
        default: begin
          size  = $urandom_range(1, 256);
          count = $urandom_range(3, 24);
        end
      endcase
      set_pool(size, count);
      // The closing phase runs without any idling.
      idle_on = (p != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      run_random_phase(ITEMS_PER_PHASE);
    end

    in_tvalid = 1'b0;
    wait (outstanding == 0);
    repeat (8) @(posedge clk);

    $display("Sent %0d requests over %0d pool settings (block sizes 1 to 256, counts 1 to 255).",
             requests_sent, settings_used);
    $display("Blocks handed out %0d, frees taken %0d, empty refusals %0d, range rejects %0d.",
             handed_out, frees_ok, empty_seen, range_seen);
    if (mismatches == 0) begin
      $display("[fixed_block_free_list_allocator] OK");
    end else begin
      $display("[fixed_block_free_list_allocator] ERROR");
    end
    $finish;
  end

endmodule

[fixed_block_free_list_allocator.f]
design/fbfa_pkg.sv
design/fbfa_ram.sv
design/fbfa_links.sv
design/fixed_block_free_list_allocator.sv
verif/alloc_result_checker.sv
verif/testbench.sv
